[rtl/core/rlp_pkg.sv]
package rlp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int PARSED_W   = 32;
  localparam int CHAR_W     = 8;
  localparam int MODE_W     = 3;
  localparam int NUM_RADIX  = 5;
  localparam int RADIX_W    = 3;
  localparam int DIGIT_W    = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int RES_DEPTH  = 2;
  localparam int RES_AW     = $clog2(RES_DEPTH);

  localparam logic [MODE_W-1:0] MODE_DEC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEX  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BIN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OCT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AUTO = 3'd5;

  localparam logic [RADIX_W-1:0] RADIX_DEC = 3'd0;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 3'd1;
  localparam logic [RADIX_W-1:0] RADIX_BIN = 3'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 3'd3;
  localparam logic [RADIX_W-1:0] RADIX_STR = 3'd4;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = '1;

  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LO_O   = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LAT_LO = 8'hC0;
  localparam logic [CHAR_W-1:0] CH_LAT_HI = 8'hDE;
  localparam logic [CHAR_W-1:0] CH_TIMES  = 8'hD7;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;
  localparam logic [CHAR_W-1:0] TEN       = 8'd10;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               auto_mode;
    logic [MODE_W-1:0]  mode;
  } cmd_t;

  typedef struct packed {
    logic [PARSED_W-1:0] value;
    logic                ok;
    logic [RADIX_W-1:0]  radix;
  } res_t;

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    logic upper;
    upper = (c >= CH_UP_A && c <= CH_UP_Z) ||
            (c >= CH_LAT_LO && c <= CH_LAT_HI && c != CH_TIMES);
    return upper ? c + CASE_OFS : c;
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_UP_A && c < CH_UP_Z) begin
      d = DIGIT_W'(c - CH_UP_A + TEN);
    end else if (c >= CH_LO_A && c < CH_LO_Z) begin
      d = DIGIT_W'(c - CH_LO_A + TEN);
    end
    return d;
  endfunction

endpackage

[rtl/core/rlp_front.sv]
module rlp_front (
  input  logic [rlp_pkg::CHAR_W-1:0] char_code,
  input  logic                       last_char,
  input  logic [rlp_pkg::MODE_W-1:0] radix_mode,
  output rlp_pkg::cmd_t              cmd
);
  import rlp_pkg::*;

  logic                auto_mode;
  logic [CHAR_W-1:0]   ch;

  assign auto_mode = radix_mode > MODE_STR;
  assign ch        = auto_mode ? to_lower(char_code) : char_code;

  always_comb begin
    cmd.ch        = ch;
    cmd.digit     = digit_of(ch);
    cmd.last      = last_char;
    cmd.auto_mode = auto_mode;
    cmd.mode      = radix_mode;
  end

endmodule

[rtl/core/rlp_cmd_queue.sv]
module rlp_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  rlp_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output rlp_pkg::cmd_t rd_data,
  output logic          empty
);
  import rlp_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   count_r;
  logic               do_wr;
  logic               do_rd;

  assign full    = count_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/rlp_back.sv]
module rlp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  rlp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output rlp_pkg::res_t res,
  output logic          res_empty,
  input  logic          res_pop
);
  import rlp_pkg::*;

  value_t                vals_r [NUM_RADIX];
  value_t                vals_nxt [NUM_RADIX];
  logic [NUM_RADIX-1:0]  alive_r, alive_nxt;
  logic [1:0]            pos_r, pos_nxt;
  logic [CHAR_W-1:0]     quote_r, quote_nxt;
  logic [CHAR_W-1:0]     pend_r, pend_nxt;

  res_t                  resq_r [RES_DEPTH];
  logic [RES_AW-1:0]     res_wp_r, res_rp_r;
  logic [RES_AW:0]       res_cnt_r;
  logic                  res_full;
  logic                  res_push;
  logic                  res_take;
  res_t                  res_new;

  logic [NUM_RADIX-1:0]  okm;
  logic                  is_quote;
  value_t                dval;

  assign res_full  = res_cnt_r == (RES_AW+1)'(RES_DEPTH);
  assign res_empty = res_cnt_r == '0;
  assign res       = resq_r[res_rp_r];
  assign cmd_pop   = cmd_valid && (!cmd.last || !res_full);
  assign res_push  = cmd_pop && cmd.last;
  assign res_take  = res_pop && !res_empty;
  assign is_quote  = cmd.ch == CH_DQUOTE || cmd.ch == CH_SQUOTE;
  assign dval      = VALUE_BITS'(cmd.digit);

  always_comb begin
    for (int k = 0; k < NUM_RADIX; k++) begin
      vals_nxt[k] = vals_r[k];
    end
    alive_nxt = alive_r;
    quote_nxt = quote_r;
    pend_nxt  = pend_r;
    pos_nxt   = (pos_r == 2'd3) ? pos_r : pos_r + 2'd1;

    if (cmd.digit >= DIGIT_W'(10)) begin
      alive_nxt[RADIX_DEC] = 1'b0;
    end else begin
      vals_nxt[RADIX_DEC] = (vals_r[RADIX_DEC] << 3) + (vals_r[RADIX_DEC] << 1) + dval;
    end

    if (pos_r == 2'd0) begin
      if (cmd.ch != CH_ZERO) begin
        alive_nxt[RADIX_HEX] = 1'b0;
        alive_nxt[RADIX_BIN] = 1'b0;
      end
      if (cmd.ch != CH_LO_O) begin
        alive_nxt[RADIX_OCT] = 1'b0;
      end
      if (is_quote) begin
        quote_nxt = cmd.ch;
      end else begin
        alive_nxt[RADIX_STR] = 1'b0;
      end
    end else begin
      if (pos_r == 2'd1) begin
        if (cmd.ch != CH_LO_X) begin
          alive_nxt[RADIX_HEX] = 1'b0;
        end
        if (cmd.ch != CH_LO_B) begin
          alive_nxt[RADIX_BIN] = 1'b0;
        end
      end else begin
        if (cmd.digit >= DIGIT_W'(16)) begin
          alive_nxt[RADIX_HEX] = 1'b0;
        end else begin
          vals_nxt[RADIX_HEX] = (vals_r[RADIX_HEX] << 4) + dval;
        end
        if (cmd.digit >= DIGIT_W'(2)) begin
          alive_nxt[RADIX_BIN] = 1'b0;
        end else begin
          vals_nxt[RADIX_BIN] = (vals_r[RADIX_BIN] << 1) + dval;
        end
        vals_nxt[RADIX_STR] = (vals_r[RADIX_STR] << 8) | VALUE_BITS'(pend_r);
      end
      if (cmd.digit >= DIGIT_W'(8)) begin
        alive_nxt[RADIX_OCT] = 1'b0;
      end else begin
        vals_nxt[RADIX_OCT] = (vals_r[RADIX_OCT] << 3) + dval;
      end
      pend_nxt = cmd.ch;
    end
  end

  always_comb begin
    okm = alive_nxt;
    if (pos_r < 2'd2) begin
      okm[RADIX_HEX] = 1'b0;
      okm[RADIX_BIN] = 1'b0;
      okm[RADIX_STR] = 1'b0;
    end
    if (pos_r == 2'd0) begin
      okm[RADIX_OCT] = 1'b0;
    end
    if (cmd.ch != quote_nxt) begin
      okm[RADIX_STR] = 1'b0;
    end

    res_new.ok    = 1'b0;
    res_new.radix = RADIX_DEC;
    if (cmd.auto_mode) begin
      priority if (okm[RADIX_DEC]) begin
        res_new.ok = 1'b1; res_new.radix = RADIX_DEC;
      end else if (okm[RADIX_HEX]) begin
        res_new.ok = 1'b1; res_new.radix = RADIX_HEX;
      end else if (okm[RADIX_BIN]) begin
        res_new.ok = 1'b1; res_new.radix = RADIX_BIN;
      end else if (okm[RADIX_OCT]) begin
        res_new.ok = 1'b1; res_new.radix = RADIX_OCT;
      end else if (okm[RADIX_STR]) begin
        res_new.ok = 1'b1; res_new.radix = RADIX_STR;
      end
    end else if (okm[cmd.mode]) begin
      res_new.ok    = 1'b1;
      res_new.radix = cmd.mode;
    end
    res_new.value = res_new.ok ? PARSED_W'(vals_nxt[res_new.radix]) : '0;
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      resq_r[res_wp_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_RADIX; k++) begin
        vals_r[k] <= '0;
      end
      alive_r   <= '1;
      pos_r     <= '0;
      quote_r   <= '0;
      pend_r    <= '0;
      res_wp_r  <= '0;
      res_rp_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (cmd_pop) begin
        if (cmd.last) begin
          for (int k = 0; k < NUM_RADIX; k++) begin
            vals_r[k] <= '0;
          end
          alive_r <= '1;
          pos_r   <= '0;
          quote_r <= '0;
          pend_r  <= '0;
        end else begin
          for (int k = 0; k < NUM_RADIX; k++) begin
            vals_r[k] <= vals_nxt[k];
          end
          alive_r <= alive_nxt;
          pos_r   <= pos_nxt;
          quote_r <= quote_nxt;
          pend_r  <= pend_nxt;
        end
      end
      if (res_push) begin
        res_wp_r <= res_wp_r + 1'b1;
      end
      if (res_take) begin
        res_rp_r <= res_rp_r + 1'b1;
      end
      if (res_push && !res_take) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end else if (res_take && !res_push) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/radix_label_parser.sv]
// Parses a number label that arrives one character per item, the last item
// of a label flagged by in_last_char, and delivers one result per label with
// the parsed value, a well-formed flag and the radix that matched. The block
// takes one character every cycle while not full; the per-character
// accumulate for all five radixes runs in a single back-end step, and a
// label's result is queued as the back end takes its final character. A
// four-entry command queue sits between the classifier and the accumulator,
// and a two-entry result queue lets the output stall without stopping input
// until a final character finds it full. The radix_mode register at address
// 0 must only be written while no label is in flight or held in the queues.
module radix_label_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [rlp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_last_char,
  output logic                           empty,
  input  logic                           pop,
  output logic [rlp_pkg::PARSED_W-1:0]   out_parsed_value,
  output logic                           out_parse_ok,
  output logic [rlp_pkg::RADIX_W-1:0]    out_found_radix,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rlp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rlp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rlp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rlp_pkg::*;

  logic [MODE_W-1:0] radix_mode_r;
  logic              cfg_wr;
  cmd_t              front_cmd;
  cmd_t              q_cmd;
  logic              q_empty;
  logic              q_pop;
  res_t              res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[CFG_ADDR_W-1];
  assign prdata = paddr[CFG_ADDR_W-1] ? '0 : CFG_DATA_W'(radix_mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_mode_r <= MODE_AUTO;
    end else if (cfg_wr) begin
      radix_mode_r <= pwdata[MODE_W-1:0];
    end
  end

  rlp_front u_front (
    .char_code  (in_char_code),
    .last_char  (in_last_char),
    .radix_mode (radix_mode_r),
    .cmd        (front_cmd)
  );

  rlp_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  rlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_parsed_value = res.value;
  assign out_parse_ok     = res.ok;
  assign out_found_radix  = res.radix;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_parse_ok |-> out_parsed_value == '0 && out_found_radix == RADIX_DEC)
    else $error("failed parse carries nonzero fields");

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_found_radix <= RADIX_STR)
    else $error("found radix out of range");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end took an item from an empty command queue");

endmodule

[tb/radix_label_parser_tb.sv]
`timescale 1ns / 100ps

module radix_label_parser_tb;
  import rlp_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int TARGET_CHARS  = 700;
  localparam int CALM_CHARS    = 600;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NOT_DIGIT     = 255;

  localparam logic [CFG_ADDR_W-1:0] RADIX_MODE_ADDR = '0;
  localparam logic [MODE_W-1:0]     MODE_SPARE_LO   = 3'd6;
  localparam logic [MODE_W-1:0]     MODE_SPARE_HI   = 3'd7;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [CHAR_W-1:0]     in_char_code;
  logic                  in_last_char;
  logic                  empty;
  logic                  pop;
  logic [PARSED_W-1:0]   out_parsed_value;
  logic                  out_parse_ok;
  logic [RADIX_W-1:0]    out_found_radix;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   chars_sent;
  logic calm;
  int   cycles;

  radix_label_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .empty            (empty),
    .pop              (pop),
    .out_parsed_value (out_parsed_value),
    .out_parse_ok     (out_parse_ok),
    .out_found_radix  (out_found_radix),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  class label_tracker;
    value_t               acc[NUM_RADIX];
    logic [NUM_RADIX-1:0] live;
    logic [1:0]           pos;
    logic [CHAR_W-1:0]    quote_ch;
    logic [CHAR_W-1:0]    held_ch;
    logic [MODE_W-1:0]    mode;
    res_t                 expected_labels[$];
    int                   mismatches;

    function new();
      mode = MODE_AUTO;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (acc[k]) acc[k] = '0;
      live = '1;
      pos = '0;
      quote_ch = '0;
      held_ch = '0;
    endfunction

    function logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
      if ((c >= "A" && c <= "Z") || (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function int digit_value(logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c < "Z") return c - "A" + 10;
      if (c >= "a" && c < "z") return c - "a" + 10;
      return NOT_DIGIT;
    endfunction

    function void feed(int k, int base, string pfx, logic [CHAR_W-1:0] c, int p, int d);
      if (p < pfx.len()) begin
        if (c != pfx[p]) live[k] = 1'b0;
      end else if (d >= base) begin
        live[k] = 1'b0;
      end else begin
        acc[k] = acc[k] * value_t'(base) + value_t'(d);
      end
    endfunction

    function void take_char(logic [CHAR_W-1:0] code, logic last);
      logic [CHAR_W-1:0]    c;
      logic                 auto_sel;
      int                   p;
      int                   d;
      int                   sel;
      logic [NUM_RADIX-1:0] okm;
      res_t                 exp_res;
      auto_sel = mode > MODE_STR;
      c = auto_sel ? fold_case(code) : code;
      p = pos;
      d = digit_value(c);
      feed(RADIX_DEC, 10, "", c, p, d);
      feed(RADIX_HEX, 16, "0x", c, p, d);
      feed(RADIX_BIN, 2, "0b", c, p, d);
      feed(RADIX_OCT, 8, "o", c, p, d);
      if (p == 0) begin
        if (c == "\"" || c == "'") quote_ch = c;
        else live[RADIX_STR] = 1'b0;
      end else begin
        if (p >= 2) acc[RADIX_STR] = {acc[RADIX_STR][VALUE_BITS-CHAR_W-1:0], held_ch};
        held_ch = c;
      end
      if (p < 3) pos = pos + 2'd1;
      if (!last) return;
      okm = live;
      if (p < 2) begin
        okm[RADIX_HEX] = 1'b0;
        okm[RADIX_BIN] = 1'b0;
        okm[RADIX_STR] = 1'b0;
      end
      if (p < 1) okm[RADIX_OCT] = 1'b0;
      if (c != quote_ch) okm[RADIX_STR] = 1'b0;
      sel = -1;
      if (auto_sel) begin
        for (int k = 0; k < NUM_RADIX; k++) begin
          if (okm[k] && sel < 0) sel = k;
        end
      end else if (okm[mode]) begin
        sel = mode;
      end
      if (sel >= 0) begin
        exp_res.value = acc[sel];
        exp_res.ok = 1'b1;
        exp_res.radix = RADIX_W'(sel);
      end else begin
        exp_res.value = '0;
        exp_res.ok = 1'b0;
        exp_res.radix = RADIX_DEC;
      end
      expected_labels.push_back(exp_res);
      restart();
    endfunction

    function void check_label(value_t v, logic ok, logic [RADIX_W-1:0] r);
      res_t e;
      if (expected_labels.size() == 0) begin
        $error("result with no label pending: value %h ok %b radix %0d", v, ok, r);
        mismatches++;
        return;
      end
      e = expected_labels.pop_front();
      if (v !== e.value) begin
        $error("parsed_value: expected %h, got %h", e.value, v);
        mismatches++;
      end
      if (ok !== e.ok) begin
        $error("parse_ok: expected %b, got %b", e.ok, ok);
        mismatches++;
      end
      if (r !== e.radix) begin
        $error("found_radix: expected %0d, got %0d", e.radix, r);
        mismatches++;
      end
    endfunction
  endclass

  label_tracker tracker;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("radix_label_parser verification failed");
      $finish;
    end
  end

  function automatic char_q_t text_chars(string t);
    char_q_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    return s;
  endfunction

  function automatic char_q_t make_label(logic [MODE_W-1:0] mode_now);
    char_q_t           s;
    int                kind;
    int                form;
    int                len;
    int                base;
    int                v;
    logic [CHAR_W-1:0] q;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      len = $urandom_range(1, 6);
      repeat (len) s.push_back(CHAR_W'($urandom_range(0, 255)));
      return s;
    end
    form = (mode_now <= MODE_STR && $urandom_range(0, 9) < 7) ? mode_now : $urandom_range(0, 4);
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
    base = 10;
    q = "'";
    case (form)
      RADIX_HEX: begin
        base = 16;
        s.push_back("0");
        s.push_back(($urandom_range(0, 3) == 0) ? "X" : "x");
      end
      RADIX_BIN: begin
        base = 2;
        s.push_back("0");
        s.push_back(($urandom_range(0, 3) == 0) ? "B" : "b");
      end
      RADIX_OCT: begin
        base = 8;
        s.push_back(($urandom_range(0, 3) == 0) ? "O" : "o");
      end
      RADIX_STR: begin
        q = $urandom_range(0, 1) ? "'" : "\"";
        s.push_back(q);
      end
      default: ;
    endcase
    repeat (len) begin
      if (form == RADIX_STR) begin
        s.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        v = $urandom_range(0, base - 1);
        if (v < 10) s.push_back(CHAR_W'("0" + v));
        else s.push_back(CHAR_W'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
      end
    end
    if (form == RADIX_STR) s.push_back(q);
    if (kind >= 70) begin
      case ($urandom_range(0, 2))
        0: s[$urandom_range(0, s.size() - 1)] = CHAR_W'($urandom_range(0, 255));
        1: begin
          len = $urandom_range(1, s.size());
          while (s.size() > len) void'(s.pop_back());
        end
        default: s[s.size() - 1] = s[s.size() - 1] ^ 8'h20;
      endcase
    end
    return s;
  endfunction

  task automatic send_char(logic [CHAR_W-1:0] c, logic last);
    int gap;
    gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.take_char(c, last);
    chars_sent++;
    calm = chars_sent >= CALM_CHARS;
  endtask

  task automatic send_label(char_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (tracker.expected_labels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic change_mode(logic [MODE_W-1:0] m);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RADIX_MODE_ADDR;
    pwdata <= CFG_DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.mode = m;
  endtask

  initial begin
    int stall;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        tracker.check_label(out_parsed_value, out_parse_ok, out_found_radix);
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    char_q_t latin_quote;
    char_q_t null_char;
    tracker = new();
    cycles = 0;
    chars_sent = 0;
    calm = 1'b0;
    push <= 1'b0;
    in_char_code <= '0;
    in_last_char <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    latin_quote = {8'h27, 8'hC0, 8'hFF, 8'h27};
    null_char = {8'h00};
    send_label(text_chars("0X1F"));
    send_label(text_chars("9"));
    send_label(text_chars("o"));
    send_label(latin_quote);
    change_mode(MODE_SPARE_HI);
    send_label(text_chars("0b1"));
    change_mode(MODE_SPARE_LO);
    send_label(text_chars("O7"));
    change_mode(MODE_DEC);
    send_label(null_char);
    change_mode(MODE_HEX);
    send_label(text_chars("0x"));
    change_mode(MODE_BIN);
    send_label(text_chars("0B1"));
    change_mode(MODE_OCT);
    send_label(text_chars("o8"));
    change_mode(MODE_STR);
    send_label(text_chars("\"\""));
    change_mode(MODE_AUTO);

    while (chars_sent < TARGET_CHARS) begin
      change_mode(MODE_W'($urandom_range(MODE_DEC, MODE_SPARE_HI)));
      repeat ($urandom_range(8, 20)) send_label(make_label(tracker.mode));
    end

    wait_drained();
    if (tracker.mismatches == 0 && tracker.expected_labels.size() == 0) begin
      $display("radix_label_parser verification clean");
    end else begin
      $display("radix_label_parser verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rlp_pkg.sv
rtl/core/rlp_front.sv
rtl/core/rlp_cmd_queue.sv
rtl/core/rlp_back.sv
rtl/core/radix_label_parser.sv
tb/radix_label_parser_tb.sv
